// ===== hw/rtl/cgpt_pkg.sv =====
package cgpt_pkg;

  localparam int TIME_W   = 64;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] MAX_EMIT = 5'd16;

  // Opcodes of the input item.
  localparam logic [2:0] OP_TIME    = 3'd0;
  localparam logic [2:0] OP_INHIBIT = 3'd1;
  localparam logic [2:0] OP_TOKEN   = 3'd2;
  localparam logic [2:0] OP_START   = 3'd3;
  localparam logic [2:0] OP_PAUSE   = 3'd4;
  localparam logic [2:0] OP_RESUME  = 3'd5;
  localparam logic [2:0] OP_STOP    = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] REG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_OFFSET    = 3'd1;
  localparam logic [2:0] REG_DELAY     = 3'd2;
  localparam logic [2:0] REG_LEAD      = 3'd3;
  localparam logic [2:0] REG_REPEAT    = 3'd4;
  localparam logic [2:0] REG_BURST     = 3'd5;
  localparam logic [2:0] REG_CREDITS   = 3'd6;
  localparam logic [2:0] REG_CREDIT_EN = 3'd7;

  // Operands for the shared 64-bit adder.
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] y;
    logic              cout;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/credit_gated_periodic_trigger_core.sv =====
// Channel   Direction  Transaction
// s_*       in         one command: time, inhibit, token, start, pause, resume or stop
// m_*       out        one trigger decision; tlast marks the last one of a command
// cfg_*     in         one register write, taken at every edge with cfg_we high
//
// Control commands, and time items while stopped, finish in the idle state.
// A time item adds the delay and compares; a slot not due ends there, an ungranted one
// advances the slot, and a granted one first emits its results; a stop burst only emits.
// The first time item of a run waits on the divider, then takes 3 adder steps.
// A stalled m_tready holds the sequencer; s_tready is low while a command is in work.
// Reset is synchronous and brings the block up stopped and paused.
module credit_gated_periodic_trigger_core
  import cgpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // time_now[63:0], busy_req[64], run_id[96:65], zero fill
  input  logic [2:0]   s_tuser,  // opcode[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // trigger_id[31:0], trigger_time[95:32],
                                 // window_start[159:96], run_out[191:160]
  output logic [0:0]   m_tuser,  // is_burst[0]
  output logic         m_tlast,  // last
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_SUBR   = 4'd2;
  localparam logic [3:0] S_ADDIV  = 4'd3;
  localparam logic [3:0] S_ADDOFS = 4'd4;
  localparam logic [3:0] S_DLY    = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_WIN    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_ADV    = 4'd9;

  // Configuration registers.
  logic [WORD_W-1:0]  interval_ticks;
  logic [WORD_W-1:0]  slot_offset;
  logic [WORD_W-1:0]  send_delay;
  logic [WORD_W-1:0]  window_lead;
  logic [COUNT_W-1:0] repeat_count;
  logic [COUNT_W-1:0] stop_burst;
  logic [15:0]        initial_credits;
  logic               credit_enable;

  // Run state.
  logic [3:0]         state;
  logic               running;
  logic               paused;
  logic               inhibited;
  logic               slot_valid;
  logic [TIME_W-1:0]  slot;
  logic [WORD_W-1:0]  credits;
  logic [WORD_W-1:0]  last_id;
  logic [WORD_W-1:0]  current_run;

  // Work registers of one command.
  logic [TIME_W-1:0]  t_reg;
  logic [TIME_W-1:0]  dl;
  logic [TIME_W-1:0]  win;
  logic [COUNT_W-1:0] emit_cnt;
  logic [COUNT_W-2:0] emit_k;
  logic               emit_burst;

  logic [TIME_W-1:0]  time_now;
  logic               busy_req;
  logic [WORD_W-1:0]  run_id;
  logic [2:0]         opcode;
  logic               accept;
  logic [WORD_W-1:0]  iv_eff;
  logic               have_credit;
  logic               grant;
  logic [COUNT_W-1:0] rep_clamp;
  logic [COUNT_W-1:0] burst_clamp;
  logic               load_out;
  logic               emit_last;
  logic [WORD_W-1:0]  next_id;

  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_rem;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign time_now = s_tdata[63:0];
  assign busy_req = s_tdata[64];
  assign run_id   = s_tdata[96:65];
  assign opcode   = s_tuser;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign iv_eff      = (interval_ticks == '0) ? WORD_W'(1) : interval_ticks;
  assign have_credit = credit_enable ? (!credits[WORD_W-1] && credits != '0) : 1'b1;
  assign grant       = !inhibited && !paused && have_credit;
  assign rep_clamp   = (repeat_count > MAX_EMIT) ? MAX_EMIT : repeat_count;
  assign burst_clamp = (stop_burst > MAX_EMIT) ? MAX_EMIT : stop_burst;

  assign load_out  = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign emit_last = ({1'b0, emit_k} + 1'b1) == emit_cnt;
  assign next_id   = last_id + 1'b1;

  assign div_start = accept && opcode == OP_TIME && running && !slot_valid;

  cgpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (time_now),
    .divisor   (iv_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    alu_req = '0;
    case (state)
      S_SUBR: begin
        alu_req.a   = t_reg;
        alu_req.b   = {{(TIME_W-WORD_W){1'b0}}, div_rem};
        alu_req.sub = 1'b1;
      end
      S_ADDIV, S_ADV: begin
        alu_req.a = slot;
        alu_req.b = {{(TIME_W-WORD_W){1'b0}}, iv_eff};
      end
      S_ADDOFS: begin
        alu_req.a = slot;
        alu_req.b = {{(TIME_W-WORD_W){1'b0}}, slot_offset};
      end
      S_DLY: begin
        alu_req.a = slot;
        alu_req.b = {{(TIME_W-WORD_W){1'b0}}, send_delay};
      end
      S_CMP: begin
        alu_req.a   = t_reg;
        alu_req.b   = dl;
        alu_req.sub = 1'b1;
      end
      S_WIN: begin
        alu_req.a   = slot;
        alu_req.b   = {{(TIME_W-WORD_W){1'b0}}, window_lead};
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  cgpt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks  <= 32'd1000;
      slot_offset     <= '0;
      send_delay      <= '0;
      window_lead     <= '0;
      repeat_count    <= 5'd1;
      stop_burst      <= '0;
      initial_credits <= '0;
      credit_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INTERVAL:  interval_ticks  <= cfg_wdata;
        REG_OFFSET:    slot_offset     <= cfg_wdata;
        REG_DELAY:     send_delay      <= cfg_wdata;
        REG_LEAD:      window_lead     <= cfg_wdata;
        REG_REPEAT:    repeat_count    <= cfg_wdata[COUNT_W-1:0];
        REG_BURST:     stop_burst      <= cfg_wdata[COUNT_W-1:0];
        REG_CREDITS:   initial_credits <= cfg_wdata[15:0];
        REG_CREDIT_EN: credit_enable   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running     <= 1'b0;
      paused      <= 1'b1;
      inhibited   <= 1'b0;
      slot_valid  <= 1'b0;
      slot        <= '0;
      credits     <= '0;
      last_id     <= '0;
      current_run <= '0;
      emit_k      <= '0;
      emit_cnt    <= '0;
      emit_burst  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            t_reg  <= time_now;
            emit_k <= '0;
            case (opcode)
              OP_TIME: begin
                if (running) begin
                  state <= slot_valid ? S_DLY : S_DIV;
                end
              end
              OP_INHIBIT: begin
                if (running) begin
                  inhibited <= busy_req;
                end
              end
              OP_TOKEN: begin
                if (running && run_id == current_run) begin
                  credits <= credits + 1'b1;
                end
              end
              OP_START: begin
                current_run <= run_id;
                paused      <= 1'b1;
                inhibited   <= 1'b0;
                running     <= 1'b1;
                credits     <= {16'd0, initial_credits};
                last_id     <= '0;
                slot_valid  <= 1'b0;
              end
              OP_PAUSE:  paused <= 1'b1;
              OP_RESUME: paused <= 1'b0;
              OP_STOP: begin
                if (running) begin
                  running    <= 1'b0;
                  slot_valid <= 1'b0;
                  if (slot_valid && stop_burst != '0) begin
                    emit_cnt   <= burst_clamp;
                    emit_burst <= 1'b1;
                    state      <= S_WIN;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SUBR;
          end
        end
        S_SUBR: begin
          slot  <= alu_rsp.y;
          state <= S_ADDIV;
        end
        S_ADDIV: begin
          slot  <= alu_rsp.y;
          state <= S_ADDOFS;
        end
        S_ADDOFS: begin
          slot       <= alu_rsp.y;
          slot_valid <= 1'b1;
          state      <= S_DLY;
        end
        S_DLY: begin
          dl    <= alu_rsp.y;
          state <= S_CMP;
        end
        S_CMP: begin
          // A carry out of the subtract means the time has reached slot plus delay.
          if (!alu_rsp.cout) begin
            state <= S_IDLE;
          end else if (grant && repeat_count != '0) begin
            emit_cnt   <= rep_clamp;
            emit_burst <= 1'b0;
            state      <= S_WIN;
          end else begin
            state <= S_ADV;
          end
        end
        S_WIN: begin
          win   <= alu_rsp.y;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            m_tvalid <= 1'b1;
            last_id  <= next_id;
            emit_k   <= emit_k + 1'b1;
            if (!emit_burst) begin
              credits <= credits - 1'b1;
            end
            if (emit_last) begin
              state <= emit_burst ? S_IDLE : S_ADV;
            end
          end
        end
        S_ADV: begin
          slot  <= alu_rsp.y;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {current_run, win, slot, next_id};
      m_tuser <= emit_burst;
      m_tlast <= emit_last;
    end
  end

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  // The result counter never runs past the count of the batch.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> ({1'b0, emit_k} < emit_cnt))
    else $error("result counter overran its batch");

  // Slot decisions keep a valid slot; a stop burst only follows the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !emit_burst) |-> slot_valid)
    else $error("slot decision without a valid slot");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_burst) |-> (!running && !slot_valid))
    else $error("stop burst while the run is still active");

endmodule

// ===== hw/rtl/cgpt_alu.sv =====
module cgpt_alu
  import cgpt_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TIME_W-1:0] b_eff;
  logic [TIME_W:0]   sum;

  // For a subtract, a carry out of one means a >= b.
  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, req.sub};
  assign rsp.y    = sum[TIME_W-1:0];
  assign rsp.cout = sum[TIME_W];

endmodule

// ===== hw/rtl/cgpt_div.sv =====
module cgpt_div
  import cgpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] remainder
);

  logic                       busy;
  logic [DIV_CNT_W-1:0]       cnt;
  logic [TIME_W-1:0]          dvd;
  logic [WORD_W-1:0]          dsr;
  logic [WORD_W-1:0]          rem;
  logic [WORD_W:0]            shifted;
  logic                       ge;
  logic [WORD_W:0]            diff;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  assign shifted   = {rem, dvd[TIME_W-1]};
  assign ge        = shifted >= {1'b0, dsr};
  assign diff      = shifted - {1'b0, dsr};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cgpt_pkg::*;

  // The opcode space has one unused code, which the block must ignore.
  localparam logic [2:0] OP_RESERVED = 3'd7;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_RUNS   = 5;
  localparam int ITEMS_PER_RUN = 24;

  typedef struct packed {
    logic [31:0] trig_id;
    logic [63:0] trig_time;
    logic [63:0] win_start;
    logic [31:0] run;
    logic        burst;
    logic        last;
  } decision_t;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [2:0]   s_tuser = OP_TIME;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = REG_INTERVAL;
  logic [31:0]  cfg_wdata = '0;

  credit_gated_periodic_trigger_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Register copy, at reset values.
  logic [31:0] interval_q = 32'd1000;
  logic [31:0] offset_q = '0;
  logic [31:0] delay_q = '0;
  logic [31:0] lead_q = '0;
  logic [4:0]  repeat_q = 5'd1;
  logic [4:0]  burst_q = '0;
  logic [15:0] init_credits_q = '0;
  logic        credit_en_q = 1'b1;

  // Trigger state copy, at reset values.
  logic               run_active = 1'b0;
  logic               run_paused = 1'b1;
  logic               busy_inhibit = 1'b0;
  logic               slot_armed = 1'b0;
  logic [63:0]        slot_time = '0;
  logic signed [31:0] credit_bal = '0;
  logic [31:0]        trig_count = '0;
  logic [31:0]        active_run = '0;

  decision_t pending_decisions[$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        quiet_cycles = 0;
  int        rx_cycle = 0;
  rx_mode_t  rx_mode = RX_STREAM;

  function automatic void emit_decisions(input logic [4:0] count_cfg, input logic from_stop);
    int        count;
    decision_t d;
    count = (count_cfg > MAX_EMIT) ? int'(MAX_EMIT) : int'(count_cfg);
    for (int k = 0; k < count; k++) begin
      trig_count  = trig_count + 32'd1;
      d.trig_id   = trig_count;
      d.trig_time = slot_time;
      d.win_start = slot_time - {32'd0, lead_q};
      d.run       = active_run;
      d.burst     = from_stop;
      d.last      = (k == count - 1);
      pending_decisions.insert(pending_decisions.size(), d);
      if (!from_stop) credit_bal = credit_bal - 32'sd1;
    end
  endfunction

  function automatic void predict_command(input logic [2:0] op, input logic [63:0] now,
                                          input logic busy, input logic [31:0] rid);
    logic [63:0] step;
    logic        has_credit;
    step = (interval_q == 32'd0) ? 64'd1 : {32'd0, interval_q};
    case (op)
      OP_TIME: begin
        if (run_active) begin
          if (!slot_armed) begin
            slot_time  = (now / step + 64'd1) * step + {32'd0, offset_q};
            slot_armed = 1'b1;
          end
          if (now >= slot_time + {32'd0, delay_q}) begin
            has_credit = credit_en_q ? (credit_bal > 0) : 1'b1;
            if (!busy_inhibit && !run_paused && has_credit) emit_decisions(repeat_q, 1'b0);
            slot_time = slot_time + step;
          end
        end
      end
      OP_INHIBIT: begin
        if (run_active) busy_inhibit = busy;
      end
      OP_TOKEN: begin
        if (run_active && rid == active_run) credit_bal = credit_bal + 32'sd1;
      end
      OP_START: begin
        active_run   = rid;
        run_paused   = 1'b1;
        busy_inhibit = 1'b0;
        run_active   = 1'b1;
        credit_bal   = {16'd0, init_credits_q};
        trig_count   = '0;
        slot_armed   = 1'b0;
      end
      OP_PAUSE:  run_paused = 1'b1;
      OP_RESUME: run_paused = 1'b0;
      OP_STOP: begin
        if (run_active) begin
          run_active = 1'b0;
          if (slot_armed && burst_q != 5'd0) emit_decisions(burst_q, 1'b1);
          slot_armed = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one command; the sender pauses for a random gap between bursts.
  task automatic send_cmd(input logic [2:0] op, input logic [63:0] now,
                          input logic busy, input logic [31:0] rid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, rid, busy, now};
    do @(posedge clk); while (!s_tready);
    predict_command(op, now, busy, rid);
  endtask

  // Waits until every expected decision has arrived and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_INTERVAL:  interval_q = value;
      REG_OFFSET:    offset_q = value;
      REG_DELAY:     delay_q = value;
      REG_LEAD:      lead_q = value;
      REG_REPEAT:    repeat_q = value[4:0];
      REG_BURST:     burst_q = value[4:0];
      REG_CREDITS:   init_credits_q = value[15:0];
      REG_CREDIT_EN: credit_en_q = value[0];
      default: ;
    endcase
  endtask

  // Writes all eight registers; with junk set, unused upper bits of the narrow
  // registers carry random values that the block must drop.
  task automatic load_config(input logic [31:0] iv, input logic [31:0] off,
                             input logic [31:0] dly, input logic [31:0] lead,
                             input logic [4:0] rep, input logic [4:0] stop_cnt,
                             input logic [15:0] creds, input logic en, input logic junk);
    logic [31:0] hi;
    hi = junk ? $urandom : 32'd0;
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_OFFSET, off);
    write_reg(REG_DELAY, dly);
    write_reg(REG_LEAD, lead);
    write_reg(REG_REPEAT, {hi[31:5], rep});
    write_reg(REG_BURST, {hi[26:0], stop_cnt});
    write_reg(REG_CREDITS, {hi[15:0], creds});
    write_reg(REG_CREDIT_EN, {hi[31:1], en});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset settings: no credit at start, so a token is needed before a grant.
  task automatic test_reset_defaults();
    send_cmd(OP_START, 64'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(OP_RESUME, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'd5000, 1'b0, 32'd0);
    send_cmd(OP_TOKEN, 64'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(OP_TIME, 64'd6000, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'd6500, 1'b0, 32'd0);
    send_cmd(OP_INHIBIT, 64'd0, 1'b1, 32'd0);
    send_cmd(OP_TOKEN, 64'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(OP_TIME, 64'd7000, 1'b0, 32'd0);
    send_cmd(OP_INHIBIT, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_PAUSE, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'd8000, 1'b0, 32'd0);
    send_cmd(OP_TOKEN, 64'd0, 1'b0, 32'd5);
    send_cmd(OP_RESUME, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_cmd(OP_STOP, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_STOP, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_INHIBIT, 64'd0, 1'b1, 32'd0);
    send_cmd(OP_TOKEN, 64'd0, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_extreme_settings();
    // Zero interval, clamped counts, credits ignored and driven negative.
    drain();
    load_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 5'd31, 5'd16, 16'd0, 1'b0, 1'b0);
    send_cmd(OP_START, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_RESUME, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0);
    send_cmd(OP_STOP, 64'd0, 1'b0, 32'd0);
    // Largest interval and delay: slot and deadline wrap past 2^64, a zero
    // repeat count grants without output, and stop emits a short burst.
    drain();
    load_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 5'd0, 5'd3, 16'hFFFF, 1'b1, 1'b0);
    send_cmd(OP_START, 64'd0, 1'b0, 32'hA5A5_5A5A);
    send_cmd(OP_RESUME, 64'd0, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 32'd0);
    send_cmd(OP_TIME, 64'd5, 1'b0, 32'd0);
    send_cmd(OP_STOP, 64'd0, 1'b0, 32'd0);
  endtask

  // Well-formed runs on a short interval with random control traffic mixed in.
  task automatic test_random_runs();
    logic [31:0] iv;
    logic [31:0] run;
    logic [63:0] now;
    int          pick;
    for (int r = 0; r < RANDOM_RUNS; r++) begin
      drain();
      iv = $urandom_range(1, 300);
      load_config(iv, $urandom_range(0, 2 * iv), $urandom_range(0, iv), $urandom,
                  5'($urandom_range(0, 20)), 5'($urandom_range(0, 20)),
                  16'($urandom_range(0, 30)), 1'($urandom_range(0, 1)), 1'b1);
      run = $urandom;
      now = rand64();
      send_cmd(OP_START, rand64(), 1'($urandom_range(0, 1)), run);
      send_cmd(OP_RESUME, rand64(), 1'($urandom_range(0, 1)), $urandom);
      for (int i = 0; i < ITEMS_PER_RUN; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          now = now + 64'($urandom_range(0, 2 * iv));
          send_cmd(OP_TIME, now, 1'($urandom_range(0, 1)), $urandom);
        end else if (pick < 74) begin
          send_cmd(OP_TOKEN, rand64(), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? $urandom : run);
        end else if (pick < 81) begin
          send_cmd(OP_INHIBIT, rand64(), 1'($urandom_range(0, 1)), $urandom);
        end else if (pick < 86) begin
          send_cmd(OP_PAUSE, rand64(), 1'($urandom_range(0, 1)), $urandom);
        end else if (pick < 93) begin
          send_cmd(OP_RESUME, rand64(), 1'($urandom_range(0, 1)), $urandom);
        end else if (pick < 97) begin
          send_cmd(3'($urandom_range(0, 7)), rand64(), 1'($urandom_range(0, 1)), $urandom);
        end else begin
          run = $urandom;
          send_cmd(OP_START, rand64(), 1'($urandom_range(0, 1)), run);
          send_cmd(OP_RESUME, rand64(), 1'($urandom_range(0, 1)), $urandom);
        end
      end
      send_cmd(OP_STOP, rand64(), 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extreme_settings();
    test_random_runs();
    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // The receiver switches between streaming, random stalls and long periodic stalls.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_STREAM:  m_tready <= 1'b1;
      RX_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
      default:    m_tready <= ((rx_cycle % 13) < 4);
    endcase
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_decisions
    decision_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_decisions.size() == 0) begin
        $error("trigger_id: expected none, got %0h", m_tdata[31:0]);
        mismatches++;
      end else begin
        want = pending_decisions.pop_front();
        check_field("trigger_id", 64'(want.trig_id), 64'(m_tdata[31:0]));
        check_field("trigger_time", want.trig_time, m_tdata[95:32]);
        check_field("window_start", want.win_start, m_tdata[159:96]);
        check_field("run_out", 64'(want.run), 64'(m_tdata[191:160]));
        check_field("is_burst", 64'(want.burst), 64'(m_tuser[0]));
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
